/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL files of the change dispenser.
// Depends on nothing; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hdl/gcdisp_pkg.sv */
// Types, constants and denomination tables of the change dispenser.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package gcdisp_pkg;

  localparam int DENOM_COUNT = 7;
  localparam int IDX_W       = 3;
  localparam int REM_W       = 15;
  localparam int COUNT_W     = 8;
  localparam int DENOM_W     = 5;
  localparam int RECIP_W     = 20;
  localparam int RECIP_SHIFT = 19;
  localparam int PROD_W      = REM_W + RECIP_W;
  localparam int TAKE_W      = COUNT_W + DENOM_W;

  localparam logic [COUNT_W-1:0] INITIAL_STOCK = 8'd2;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] amount;
  } in_t;

  typedef struct packed {
    logic       status;
    logic [7:0] given_17;
    logic [7:0] given_11;
    logic [7:0] given_7;
    logic [7:0] given_5;
    logic [7:0] given_3;
    logic [7:0] given_2;
    logic [7:0] given_1;
  } out_t;

  localparam logic CMD_PAY    = 1'b0;
  localparam logic CMD_REFILL = 1'b1;

  localparam logic STATUS_DONE     = 1'b0;
  localparam logic STATUS_NO_CHANGE = 1'b1;

  typedef struct packed {
    logic             load;
    logic             refill;
    logic             div;
    logic             sub;
    logic             finish;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic is_refill;
    logic amount_pos;
  } dp_stat_t;

  function automatic logic [DENOM_W-1:0] denom_value(input logic [IDX_W-1:0] idx);
    logic [DENOM_W-1:0] v;
    case (idx)
      3'd0:    v = 5'd17;
      3'd1:    v = 5'd11;
      3'd2:    v = 5'd7;
      3'd3:    v = 5'd5;
      3'd4:    v = 5'd3;
      3'd5:    v = 5'd2;
      default: v = 5'd1;
    endcase
    return v;
  endfunction

  // ceil(2**RECIP_SHIFT / value), exact floor division for any 15-bit dividend
  function automatic logic [RECIP_W-1:0] denom_recip(input logic [IDX_W-1:0] idx);
    logic [RECIP_W-1:0] m;
    case (idx)
      3'd0:    m = 20'd30841;
      3'd1:    m = 20'd47663;
      3'd2:    m = 20'd74899;
      3'd3:    m = 20'd104858;
      3'd4:    m = 20'd174763;
      3'd5:    m = 20'd262144;
      default: m = 20'd524288;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

/* hdl/gcdisp_dp.sv */
// Datapath of the change dispenser: stock, remaining amount, quotient and take counts.
// Depends on gcdisp_pkg; driven by commands from gcdisp_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module gcdisp_dp import gcdisp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_t      in_data,
  input  wire dp_cmd_t  cmd,
  output dp_stat_t      stat,
  output out_t          out_data
);

  logic [COUNT_W-1:0] stock_r [DENOM_COUNT];
  logic [COUNT_W-1:0] stock_nxt [DENOM_COUNT];
  logic [COUNT_W-1:0] take_r [DENOM_COUNT];
  logic [COUNT_W-1:0] take_nxt [DENOM_COUNT];
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [REM_W-1:0]   quot_r, quot_nxt;
  out_t               out_r, out_nxt;

  logic [PROD_W-1:0]  prod;
  logic [COUNT_W-1:0] stock_sel;
  logic [COUNT_W-1:0] n_take;
  logic [TAKE_W-1:0]  take_amt;
  logic               success;

  assign stat.is_refill  = (in_data.cmd == CMD_REFILL);
  assign stat.amount_pos = !in_data.amount[15] && (in_data.amount != 16'sd0);

  assign prod      = PROD_W'(rem_r) * PROD_W'(denom_recip(cmd.idx));
  assign stock_sel = stock_r[cmd.idx];
  assign n_take    = (quot_r < REM_W'(stock_sel)) ? quot_r[COUNT_W-1:0] : stock_sel;
  assign take_amt  = TAKE_W'(n_take) * TAKE_W'(denom_value(cmd.idx));
  assign success   = (rem_r == '0);

  always_comb begin
    stock_nxt = stock_r;
    take_nxt  = take_r;
    rem_nxt   = rem_r;
    quot_nxt  = quot_r;
    out_nxt   = out_r;
    if (cmd.load) begin
      rem_nxt = stat.amount_pos ? in_data.amount[REM_W-1:0] : '0;
      for (int i = 0; i < DENOM_COUNT; i++) take_nxt[i] = '0;
    end
    if (cmd.refill) begin
      rem_nxt = '0;
      for (int i = 0; i < DENOM_COUNT; i++) begin
        take_nxt[i]  = '0;
        stock_nxt[i] = INITIAL_STOCK;
      end
    end
    if (cmd.div) begin
      quot_nxt = prod[RECIP_SHIFT +: REM_W];
    end
    if (cmd.sub) begin
      take_nxt[cmd.idx] = n_take;
      rem_nxt = rem_r - REM_W'(take_amt);
    end
    if (cmd.finish) begin
      out_nxt.status   = success ? STATUS_DONE : STATUS_NO_CHANGE;
      out_nxt.given_17 = success ? take_r[0] : '0;
      out_nxt.given_11 = success ? take_r[1] : '0;
      out_nxt.given_7  = success ? take_r[2] : '0;
      out_nxt.given_5  = success ? take_r[3] : '0;
      out_nxt.given_3  = success ? take_r[4] : '0;
      out_nxt.given_2  = success ? take_r[5] : '0;
      out_nxt.given_1  = success ? take_r[6] : '0;
      if (success) begin
        for (int i = 0; i < DENOM_COUNT; i++) stock_nxt[i] = stock_r[i] - take_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DENOM_COUNT; i++) stock_r[i] <= INITIAL_STOCK;
    end else begin
      stock_r <= stock_nxt;
    end
  end

  always_ff @(posedge clk) begin
    take_r <= take_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    out_r  <= out_nxt;
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

/* hdl/gcdisp_ctrl.sv */
// Controller of the change dispenser: sequences load, divide, subtract and finish.
// Depends on gcdisp_pkg; drives gcdisp_dp through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module gcdisp_ctrl import gcdisp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire dp_stat_t stat,
  output logic          busy,
  output logic          out_valid,
  output dp_cmd_t       cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SUB,
    ST_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  logic             last;

  assign accept = start && (state_r == ST_IDLE);
  assign last   = (idx_r == IDX_W'(DENOM_COUNT - 1));

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    cmd.idx       = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          idx_nxt = '0;
          if (stat.is_refill) begin
            cmd.refill = 1'b1;
            state_nxt  = ST_FIN;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = stat.amount_pos ? ST_DIV : ST_FIN;
          end
        end
      end
      ST_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = ST_SUB;
      end
      ST_SUB: begin
        cmd.sub = 1'b1;
        if (last) begin
          state_nxt = ST_FIN;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_FIN: begin
        cmd.finish    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* hdl/greedy_change_dispenser_unit.sv */
// Top level of the change dispenser: controller plus datapath.
// Depends on gcdisp_pkg, gcdisp_ctrl, gcdisp_dp and assert_macros.svh.
//
// A command is taken when start is high and busy is low. A pay-out of a positive
// amount walks the seven denominations largest first, each in a divide state and a
// subtract state (a shared reciprocal multiplier for the quotient, then the stock
// limit and subtract), and then a finish state. A refill or a non-positive amount
// goes from idle straight to the finish state. The result is shown for exactly
// one cycle with out_valid high, starting at the edge where busy falls; the
// receiver cannot stall it, so it must capture every strobe.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module greedy_change_dispenser_unit import gcdisp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_data,
  output logic      out_valid,
  output out_t      out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  gcdisp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  gcdisp_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

  `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted transfer did not raise busy")
  `ASSERT_IMPLIES(a_out_after_busy, clk, rst_n, out_valid, $past(busy), "result strobe without prior work")
  `ASSERT_IMPLIES(a_fail_zero, clk, rst_n, out_valid && (out_data.status == STATUS_NO_CHANGE), (out_data.given_17 == 8'd0) && (out_data.given_11 == 8'd0) && (out_data.given_7 == 8'd0) && (out_data.given_5 == 8'd0) && (out_data.given_3 == 8'd0) && (out_data.given_2 == 8'd0) && (out_data.given_1 == 8'd0), "failed pay-out reports nonzero counts")

endmodule

`default_nettype wire
